/* rtl/t3c_pkg.sv */
// Package for the type-3 compensator: widths, register codes and beat payload types.
// No dependencies; used by the interfaces and by the top level.
package t3c_pkg;

    localparam int SCALE_SHIFT = 12;

    localparam int COEF_W  = 16;
    localparam int ERR_W   = 13;
    localparam int DUTY_W  = 16;
    localparam int REM_W   = SCALE_SHIFT + 1;
    localparam int ACC_W   = 36;
    localparam int NUM_REG = 8;
    localparam int IDX_W   = $clog2(NUM_REG);

    typedef enum logic [IDX_W-1:0] {
        REG_B0    = 3'd0,
        REG_B1    = 3'd1,
        REG_B2    = 3'd2,
        REG_B3    = 3'd3,
        REG_A1    = 3'd4,
        REG_A2    = 3'd5,
        REG_A3    = 3'd6,
        REG_FLOOR = 3'd7
    } reg_index_t;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic        [DUTY_W-1:0] duty_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [REM_W-1:0]  rem_t;

    typedef struct packed {
        reg_index_t          index;
        logic [COEF_W-1:0]   data;
    } cfg_beat_t;

    typedef struct packed {
        err_t  error_sample;
        duty_t duty_ceiling;
    } sample_beat_t;

    typedef struct packed {
        duty_t duty;
    } result_beat_t;

endpackage

/* rtl/t3c_if.sv */
// Valid/ready channel interfaces for the type-3 compensator.
// Depends on t3c_pkg for the beat payload types.
interface t3c_cfg_if;
    logic               valid;
    logic               ready;
    t3c_pkg::cfg_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface t3c_sample_if;
    logic                  valid;
    logic                  ready;
    t3c_pkg::sample_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface t3c_result_if;
    logic                  valid;
    logic                  ready;
    t3c_pkg::result_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/type3_compensator_iir.sv */
// Top level of the type-3 compensator: third-order IIR with clamped duty output.
// Depends on t3c_pkg and the channel interfaces in t3c_if.sv.
//
// One error sample beat gives one duty beat. A beat is captured in an input
// register, and the full filter sum, truncating divide by 2^SCALE_SHIFT, clamp and
// history update are combinational into the result register, so one beat per clock
// is sustained while result is ready. The rate is set by the recursion through
// the previous duty, which must be ready before the next sample is summed. Taking a
// clamp clears the carried remainder. Coefficients and duty_floor reset to zero and
// are written through cfg, which is always ready.
module type3_compensator_iir (
    input  logic              clk,
    input  logic              rst_n,
    t3c_cfg_if.sink           cfg,
    t3c_sample_if.sink        sample,
    t3c_result_if.source      result
);

    localparam int S = t3c_pkg::SCALE_SHIFT;

    t3c_pkg::coef_t coef_b_reg [4];
    t3c_pkg::coef_t coef_a_reg [1:3];
    t3c_pkg::duty_t floor_reg;

    t3c_pkg::err_t  err_hist_reg  [3];
    t3c_pkg::duty_t duty_hist_reg [3];
    t3c_pkg::rem_t  rem_reg;

    logic           s1_valid_reg;
    t3c_pkg::err_t  s1_err_reg;
    t3c_pkg::duty_t s1_ceil_reg;

    logic           out_valid_reg;
    t3c_pkg::duty_t out_duty_reg;

    logic           load_out;
    logic           advance;

    t3c_pkg::acc_t  prod [7];
    t3c_pkg::acc_t  acc;
    t3c_pkg::acc_t  bias;
    t3c_pkg::acc_t  quot;
    t3c_pkg::acc_t  rest;
    t3c_pkg::acc_t  ceil_ext;
    t3c_pkg::acc_t  floor_ext;
    t3c_pkg::duty_t duty_next;
    t3c_pkg::rem_t  rem_next;

    assign cfg.ready    = 1'b1;
    assign load_out     = !out_valid_reg || result.ready;
    assign advance      = s1_valid_reg && load_out;
    assign sample.ready = !s1_valid_reg || load_out;

    assign result.valid     = out_valid_reg;
    assign result.data.duty = out_duty_reg;

    function automatic t3c_pkg::acc_t mul_err(t3c_pkg::coef_t c, t3c_pkg::err_t e);
        logic signed [t3c_pkg::COEF_W+t3c_pkg::ERR_W-1:0] p;
        p = c * e;
        return t3c_pkg::ACC_W'(p);
    endfunction

    function automatic t3c_pkg::acc_t mul_duty(t3c_pkg::coef_t c, t3c_pkg::duty_t d);
        logic signed [t3c_pkg::DUTY_W:0]                de;
        logic signed [t3c_pkg::COEF_W+t3c_pkg::DUTY_W:0] p;
        de = signed'({1'b0, d});
        p  = c * de;
        return t3c_pkg::ACC_W'(p);
    endfunction

    always_comb
    begin
        prod[0] = mul_err(coef_b_reg[0], s1_err_reg);
        prod[1] = mul_err(coef_b_reg[1], err_hist_reg[0]);
        prod[2] = mul_err(coef_b_reg[2], err_hist_reg[1]);
        prod[3] = mul_err(coef_b_reg[3], err_hist_reg[2]);
        prod[4] = mul_duty(coef_a_reg[1], duty_hist_reg[0]);
        prod[5] = mul_duty(coef_a_reg[2], duty_hist_reg[1]);
        prod[6] = mul_duty(coef_a_reg[3], duty_hist_reg[2]);

        acc = prod[0] + prod[1] + prod[2] + prod[3] + prod[4] + prod[5] + prod[6]
            + t3c_pkg::ACC_W'(rem_reg);

        // truncate toward zero
        bias = acc[t3c_pkg::ACC_W-1]
             ? signed'({{(t3c_pkg::ACC_W - S){1'b0}}, {S{1'b1}}})
             : '0;
        quot = (acc + bias) >>> S;
        rest = acc - (quot <<< S);

        ceil_ext  = signed'({{(t3c_pkg::ACC_W - t3c_pkg::DUTY_W){1'b0}}, s1_ceil_reg});
        floor_ext = signed'({{(t3c_pkg::ACC_W - t3c_pkg::DUTY_W){1'b0}}, floor_reg});

        priority if (quot > ceil_ext)
        begin
            duty_next = s1_ceil_reg;
            rem_next  = '0;
        end
        else if (quot < floor_ext)
        begin
            duty_next = floor_reg;
            rem_next  = '0;
        end
        else
        begin
            duty_next = quot[t3c_pkg::DUTY_W-1:0];
            rem_next  = rest[t3c_pkg::REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                coef_b_reg[i] <= '0;
            end
            for (int i = 1; i < 4; i++)
            begin
                coef_a_reg[i] <= '0;
            end
            floor_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.data.index)
                t3c_pkg::REG_B0:    coef_b_reg[0] <= signed'(cfg.data.data);
                t3c_pkg::REG_B1:    coef_b_reg[1] <= signed'(cfg.data.data);
                t3c_pkg::REG_B2:    coef_b_reg[2] <= signed'(cfg.data.data);
                t3c_pkg::REG_B3:    coef_b_reg[3] <= signed'(cfg.data.data);
                t3c_pkg::REG_A1:    coef_a_reg[1] <= signed'(cfg.data.data);
                t3c_pkg::REG_A2:    coef_a_reg[2] <= signed'(cfg.data.data);
                t3c_pkg::REG_A3:    coef_a_reg[3] <= signed'(cfg.data.data);
                t3c_pkg::REG_FLOOR: floor_reg     <= cfg.data.data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                err_hist_reg[i]  <= '0;
                duty_hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (sample.valid && sample.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                rem_reg          <= rem_next;
                err_hist_reg[2]  <= err_hist_reg[1];
                err_hist_reg[1]  <= err_hist_reg[0];
                err_hist_reg[0]  <= s1_err_reg;
                duty_hist_reg[2] <= duty_hist_reg[1];
                duty_hist_reg[1] <= duty_hist_reg[0];
                duty_hist_reg[0] <= duty_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_err_reg  <= sample.data.error_sample;
            s1_ceil_reg <= sample.data.duty_ceiling;
        end
        if (advance)
        begin
            out_duty_reg <= duty_next;
        end
    end

endmodule

/* dv/type3_compensator_iir_tb.sv */
// Self-checking testbench for type3_compensator_iir: directed and random error samples
// with soft-start ceiling ramps, per-beat duty prediction and in-order comparison.
// Depends on t3c_pkg, the channel interfaces in t3c_if.sv and the top level.
module type3_compensator_iir_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_SAMPLES = 160;

    typedef enum {PH_TRACKING, PH_WILD, PH_CORNER} coef_style_t;
    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} rdy_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    t3c_cfg_if    cfg_ch ();
    t3c_sample_if sample_ch ();
    t3c_result_if result_ch ();

    type3_compensator_iir DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sample (sample_ch),
        .result (result_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    t3c_pkg::cfg_beat_t    pending_reg_writes[$];
    t3c_pkg::sample_beat_t pending_samples[$];
    t3c_pkg::result_beat_t duty_expected_q[$];
    int                    mismatches = 0;

    // filter model state
    t3c_pkg::coef_t   coef_ff [0:3];
    t3c_pkg::coef_t   coef_fb [1:3];
    t3c_pkg::duty_t   floor_reg;
    t3c_pkg::err_t    err_hist [0:2];
    t3c_pkg::duty_t   duty_hist [0:2];
    longint           carry_rem;

    function automatic void apply_reg_write(t3c_pkg::cfg_beat_t w);
        case (w.index)
            t3c_pkg::REG_B0:    coef_ff[0] = t3c_pkg::coef_t'(w.data);
            t3c_pkg::REG_B1:    coef_ff[1] = t3c_pkg::coef_t'(w.data);
            t3c_pkg::REG_B2:    coef_ff[2] = t3c_pkg::coef_t'(w.data);
            t3c_pkg::REG_B3:    coef_ff[3] = t3c_pkg::coef_t'(w.data);
            t3c_pkg::REG_A1:    coef_fb[1] = t3c_pkg::coef_t'(w.data);
            t3c_pkg::REG_A2:    coef_fb[2] = t3c_pkg::coef_t'(w.data);
            t3c_pkg::REG_A3:    coef_fb[3] = t3c_pkg::coef_t'(w.data);
            t3c_pkg::REG_FLOOR: floor_reg = w.data;
            default:   ;
        endcase
    endfunction

    function automatic t3c_pkg::duty_t predict_duty(t3c_pkg::sample_beat_t s);
        longint acc;
        longint quo;
        longint rem;
        longint scale;
        scale = longint'(1) << t3c_pkg::SCALE_SHIFT;
        acc = longint'(coef_ff[0]) * longint'(s.error_sample)
            + longint'(coef_ff[1]) * longint'(err_hist[0])
            + longint'(coef_ff[2]) * longint'(err_hist[1])
            + longint'(coef_ff[3]) * longint'(err_hist[2])
            + longint'(coef_fb[1]) * longint'(duty_hist[0])
            + longint'(coef_fb[2]) * longint'(duty_hist[1])
            + longint'(coef_fb[3]) * longint'(duty_hist[2])
            + carry_rem;
        quo = acc / scale;
        rem = acc - quo * scale;
        // ceiling wins over floor; any clamp drops the remainder
        if (quo > longint'(s.duty_ceiling))
        begin
            quo = longint'(s.duty_ceiling);
            rem = 0;
        end
        else if (quo < longint'(floor_reg))
        begin
            quo = longint'(floor_reg);
            rem = 0;
        end
        carry_rem = rem;
        err_hist[2] = err_hist[1];
        err_hist[1] = err_hist[0];
        err_hist[0] = s.error_sample;
        duty_hist[2] = duty_hist[1];
        duty_hist[1] = duty_hist[0];
        duty_hist[0] = t3c_pkg::duty_t'(quo);
        return t3c_pkg::duty_t'(quo);
    endfunction

    // driver
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.data <= '0;
            sample_ch.valid <= 1'b0;
            sample_ch.data <= '0;
        end
        else
        begin
            if (!cfg_ch.valid || cfg_ch.ready)
            begin
                if (pending_reg_writes.size() > 0)
                begin
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.data <= pending_reg_writes.pop_front();
                end
                else
                    cfg_ch.valid <= 1'b0;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    sample_ch.valid <= 1'b0;
                    gap_left--;
                end
                else if (pending_samples.size() > 0)
                begin
                    sample_ch.valid <= 1'b1;
                    sample_ch.data <= pending_samples.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                        burst_left--;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    rdy_mode_t ready_mode = RDY_ALWAYS;
    int        mode_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = rdy_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left--;
            case (ready_mode)
                RDY_ALWAYS:  result_ch.ready <= 1'b1;
                RDY_COIN:    result_ch.ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE:  result_ch.ready <= ($urandom_range(0, 3) == 0);
                default:     result_ch.ready <= ((mode_left % 6) < 3);
            endcase
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : monitor
        t3c_pkg::result_beat_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                coef_ff[i] = '0;
            for (int i = 1; i < 4; i++)
                coef_fb[i] = '0;
            for (int i = 0; i < 3; i++)
            begin
                err_hist[i] = '0;
                duty_hist[i] = '0;
            end
            floor_reg = '0;
            carry_rem = 0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                apply_reg_write(cfg_ch.data);
            if (sample_ch.valid && sample_ch.ready)
            begin
                want.duty = predict_duty(sample_ch.data);
                duty_expected_q.push_back(want);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (duty_expected_q.size() == 0)
                begin
                    $display("%0t: duty beat with none expected, expected none, actual %0d",
                             $time, result_ch.data.duty);
                    mismatches++;
                end
                else
                begin
                    want = duty_expected_q.pop_front();
                    if (result_ch.data.duty !== want.duty)
                    begin
                        $display("%0t: duty expected %0d, actual %0d",
                                 $time, want.duty, result_ch.data.duty);
                        mismatches++;
                    end
                end
            end
        end
    end

    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("type3_compensator_iir: mismatch");
            $finish;
        end
    end

    task automatic queue_sample(int e, int ceiling);
        t3c_pkg::sample_beat_t s;
        s.error_sample = t3c_pkg::err_t'(e);
        s.duty_ceiling = t3c_pkg::duty_t'(ceiling);
        pending_samples.push_back(s);
    endtask

    task automatic wait_filter_idle();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || sample_ch.valid || duty_expected_q.size() != 0);
    endtask

    task automatic program_filter(logic [15:0] vals [0:7]);
        t3c_pkg::cfg_beat_t w;
        for (int i = 0; i < t3c_pkg::NUM_REG; i++)
        begin
            w.index = t3c_pkg::reg_index_t'(i);
            w.data = vals[i];
            pending_reg_writes.push_back(w);
        end
        do
            @(posedge clk);
        while (pending_reg_writes.size() != 0 || cfg_ch.valid);
    endtask

    task automatic run_random_phase(coef_style_t style, int n);
        logic [15:0] vals [0:7];
        int          ceil_now;
        int          ceil_target;
        int          ceil_step;
        int          e;
        int          c;
        case (style)
            PH_TRACKING:
            begin
                vals[t3c_pkg::REG_B0] = 16'(int'($urandom_range(0, 8192)) - 4096);
                vals[t3c_pkg::REG_B1] = 16'(int'($urandom_range(0, 8192)) - 4096);
                vals[t3c_pkg::REG_B2] = 16'(int'($urandom_range(0, 4096)) - 2048);
                vals[t3c_pkg::REG_B3] = 16'(int'($urandom_range(0, 1024)) - 512);
                vals[t3c_pkg::REG_A1] = 16'(int'($urandom_range(3584, 4608)));
                vals[t3c_pkg::REG_A2] = 16'(int'($urandom_range(0, 2048)) - 1024);
                vals[t3c_pkg::REG_A3] = 16'(int'($urandom_range(0, 1024)) - 512);
                vals[t3c_pkg::REG_FLOOR] = 16'($urandom_range(0, 1000));
            end
            PH_WILD:
                for (int i = 0; i < t3c_pkg::NUM_REG; i++)
                    vals[i] = 16'($urandom_range(0, 65535));
            default:
                for (int i = 0; i < t3c_pkg::NUM_REG; i++)
                    case ($urandom_range(0, 4))
                        0:       vals[i] = 16'h8000;
                        1:       vals[i] = 16'h7FFF;
                        2:       vals[i] = 16'h0000;
                        3:       vals[i] = 16'hFFFF;
                        default: vals[i] = 16'h0001;
                    endcase
        endcase
        program_filter(vals);
        // soft-start: ceiling ramps from zero to its target, with occasional odd ceilings
        ceil_now = 0;
        ceil_target = $urandom_range(1000, 65535);
        ceil_step = $urandom_range(50, 2000);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0:       e = ($urandom_range(0, 1) != 0) ? 4095 : -4096;
                1, 2:    e = int'($urandom_range(0, 8191)) - 4096;
                default: e = int'($urandom_range(0, 128)) - 64;
            endcase
            ceil_now = (ceil_now + ceil_step > ceil_target) ? ceil_target : ceil_now + ceil_step;
            c = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : ceil_now;
            queue_sample(e, c);
        end
        wait_filter_idle();
    endtask

    initial
    begin
        logic [15:0] vals [0:7];
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // registers still at reset values
        queue_sample(4095, 65535);
        queue_sample(-4096, 0);
        wait_filter_idle();

        // integrator with floor: clamps, remainder carry, floor above ceiling
        vals = '{16'd3000, -16'sd2000, 16'd500, -16'sd7, 16'd4096, 16'd0, 16'd0, 16'd100};
        program_filter(vals);
        queue_sample(0, 65535);
        queue_sample(4095, 65535);
        queue_sample(4095, 65535);
        queue_sample(-4096, 65535);
        queue_sample(-4096, 65535);
        queue_sample(-1, 65535);
        queue_sample(1, 65535);
        queue_sample(4095, 0);
        queue_sample(-4096, 50);
        queue_sample(0, 50);
        queue_sample(13, 300);
        queue_sample(-13, 300);
        queue_sample(7, 300);
        queue_sample(5, 300);
        wait_filter_idle();

        // coefficient and floor extremes
        vals = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF};
        program_filter(vals);
        queue_sample(-4096, 65535);
        queue_sample(4095, 65535);
        queue_sample(4095, 65535);
        queue_sample(0, 0);
        wait_filter_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                1:       run_random_phase(PH_WILD, PHASE_SAMPLES);
                3:       run_random_phase(PH_CORNER, PHASE_SAMPLES);
                default: run_random_phase(PH_TRACKING, PHASE_SAMPLES);
            endcase
        end

        wait_filter_idle();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("type3_compensator_iir: match");
        else
            $display("type3_compensator_iir: mismatch");
        $finish;
    end

endmodule
